// ===== rtl/core/tcm_pkg.sv =====
// Package for the tricopter mixer with altitude hold: shared types, register map
// codes, reset values and the divide-by-three constants.
// No dependencies; tcm_cfg, tcm_hold, tcm_mix and the top level in rtl/core import it.
package tcm_pkg;

    // Configuration port geometry: six 32-bit registers at byte address 4*i.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_BARO_ON_LEVEL = 3'd0,
        REG_NEUTRAL_ZONE  = 3'd1,
        REG_MIN_THROTTLE  = 3'd2,
        REG_PULSE_MAX     = 3'd3,
        REG_PULSE_MIN     = 3'd4,
        REG_PULSE_CENTER  = 3'd5
    } tcm_reg_t;

    // Register reset values.
    localparam logic [11:0] BARO_ON_LEVEL_RST = 12'd1300;
    localparam logic [11:0] NEUTRAL_ZONE_RST  = 12'd40;
    localparam logic [11:0] MIN_THROTTLE_RST  = 12'd1100;
    localparam logic [11:0] PULSE_MAX_RST     = 12'd2000;
    localparam logic [11:0] PULSE_MIN_RST     = 12'd1000;
    localparam logic [11:0] PULSE_CENTER_RST  = 12'd1500;

    // Divide by three as multiply by ceil(2^17/3) and shift; exact for operands below 2^16.
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // Largest value of a 12-bit output.
    localparam logic [11:0] OUT_MAX = 12'hFFF;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [11:0] baro_on_level;
        logic [11:0] neutral_zone;
        logic [11:0] min_throttle;
        logic [11:0] pulse_max;
        logic [11:0] pulse_min;
        logic [11:0] pulse_center;
    } tcm_cfg_t;

    // One input beat.
    typedef struct packed {
        logic [11:0]        throttle_in;
        logic [11:0]        baro_switch;
        logic [11:0]        yaw_stick;
        logic signed [11:0] pitch_correction;
        logic signed [11:0] roll_correction;
        logic signed [11:0] yaw_correction;
        logic signed [11:0] baro_correction;
        logic signed [23:0] est_altitude;
    } tcm_in_t;

    // One result beat.
    typedef struct packed {
        logic [11:0]        motor_left;
        logic [11:0]        motor_right;
        logic [11:0]        motor_rear;
        logic [11:0]        tail_servo;
        logic               hold_active;
        logic               hold_engaged;
        logic signed [23:0] altitude_target;
    } tcm_out_t;

    // Hold latch outcome handed to the mixer.
    typedef struct packed {
        logic signed [13:0] thr_eff;
        logic               engaged;
        logic               active;
    } tcm_hold_t;

endpackage

// ===== rtl/core/tcm_if.sv =====
// Valid/ready channel interfaces for the input and result beats of the mixer.
// Depends on nothing; field widths follow the tcm_pkg beat structs.
interface tcm_in_if;
    logic               valid;
    logic               ready;
    logic [11:0]        throttle_in;
    logic [11:0]        baro_switch;
    logic [11:0]        yaw_stick;
    logic signed [11:0] pitch_correction;
    logic signed [11:0] roll_correction;
    logic signed [11:0] yaw_correction;
    logic signed [11:0] baro_correction;
    logic signed [23:0] est_altitude;

    modport source (
        output valid, throttle_in, baro_switch, yaw_stick, pitch_correction,
               roll_correction, yaw_correction, baro_correction, est_altitude,
        input  ready
    );
    modport sink (
        input  valid, throttle_in, baro_switch, yaw_stick, pitch_correction,
               roll_correction, yaw_correction, baro_correction, est_altitude,
        output ready
    );
endinterface

interface tcm_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        motor_left;
    logic [11:0]        motor_right;
    logic [11:0]        motor_rear;
    logic [11:0]        tail_servo;
    logic               hold_active;
    logic               hold_engaged;
    logic signed [23:0] altitude_target;

    modport source (
        output valid, motor_left, motor_right, motor_rear, tail_servo,
               hold_active, hold_engaged, altitude_target,
        input  ready
    );
    modport sink (
        input  valid, motor_left, motor_right, motor_rear, tail_servo,
               hold_active, hold_engaged, altitude_target,
        output ready
    );
endinterface

// ===== rtl/core/tcm_cfg.sv =====
// APB-style configuration register bank for the mixer.
// Depends on tcm_pkg for the register map, reset values and config struct.
module tcm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcm_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tcm_pkg::tcm_cfg_t             cfg
);
    import tcm_pkg::*;

    tcm_cfg_t  cfg_reg;
    tcm_cfg_t  cfg_next;
    tcm_reg_t  reg_sel;
    logic      wr_en;
    logic [11:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = tcm_reg_t'(paddr[PADDR_W-1:2]);

    // Register write decode; unmapped addresses are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BARO_ON_LEVEL: cfg_next.baro_on_level = pwdata[11:0];
                REG_NEUTRAL_ZONE:  cfg_next.neutral_zone  = pwdata[11:0];
                REG_MIN_THROTTLE:  cfg_next.min_throttle  = pwdata[11:0];
                REG_PULSE_MAX:     cfg_next.pulse_max     = pwdata[11:0];
                REG_PULSE_MIN:     cfg_next.pulse_min     = pwdata[11:0];
                REG_PULSE_CENTER:  cfg_next.pulse_center  = pwdata[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baro_on_level <= BARO_ON_LEVEL_RST;
            cfg_reg.neutral_zone  <= NEUTRAL_ZONE_RST;
            cfg_reg.min_throttle  <= MIN_THROTTLE_RST;
            cfg_reg.pulse_max     <= PULSE_MAX_RST;
            cfg_reg.pulse_min     <= PULSE_MIN_RST;
            cfg_reg.pulse_center  <= PULSE_CENTER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_sel)
            REG_BARO_ON_LEVEL: rd_val = cfg_reg.baro_on_level;
            REG_NEUTRAL_ZONE:  rd_val = cfg_reg.neutral_zone;
            REG_MIN_THROTTLE:  rd_val = cfg_reg.min_throttle;
            REG_PULSE_MAX:     rd_val = cfg_reg.pulse_max;
            REG_PULSE_MIN:     rd_val = cfg_reg.pulse_min;
            REG_PULSE_CENTER:  rd_val = cfg_reg.pulse_center;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-12){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

// ===== rtl/core/tcm_hold.sv =====
// Altitude-hold latch: engage, release and the effective throttle, with the
// held throttle and target altitude registers. Depends on tcm_pkg.
module tcm_hold (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tcm_pkg::tcm_cfg_t         cfg,
    input  logic [11:0]               throttle_in,
    input  logic [11:0]               baro_switch,
    input  logic signed [11:0]        baro_correction,
    input  logic signed [23:0]        est_altitude,
    output tcm_pkg::tcm_hold_t        hold,
    output logic signed [23:0]        target_next
);
    import tcm_pkg::*;

    logic               latch_reg;
    logic [11:0]        held_reg;
    logic signed [23:0] target_reg;

    logic               sw_low;
    logic               engage;
    logic [11:0]        held_eff;
    logic signed [12:0] diff;
    logic [11:0]        diff_mag;
    logic               release_hold;
    logic signed [13:0] baro_add;

    // A low switch sets the latch; a clear latch then captures throttle and altitude.
    assign sw_low   = (baro_switch <= cfg.baro_on_level);
    assign engage   = sw_low && !latch_reg;
    assign held_eff = engage ? throttle_in : held_reg;

    // Stick departure from the held throttle beyond the neutral zone releases hold.
    assign diff         = $signed({1'b0, throttle_in}) - $signed({1'b0, held_eff});
    assign diff_mag     = diff[12] ? 12'(-diff) : diff[11:0];
    assign release_hold = (diff_mag > cfg.neutral_zone);

    // On the engage tick the altitude correction counts as zero.
    assign baro_add = engage ? 14'sd0 : 14'(baro_correction);

    always_comb
    begin
        hold.engaged = engage;
        hold.active  = sw_low && !release_hold;
        if (sw_low)
        begin
            hold.thr_eff = $signed({2'b00, held_eff}) + baro_add;
        end
        else
        begin
            hold.thr_eff = $signed({2'b00, throttle_in});
        end
    end

    assign target_next = engage ? est_altitude : target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= 1'b0;
            held_reg   <= '0;
            target_reg <= '0;
        end
        else if (en)
        begin
            latch_reg  <= hold.active;
            held_reg   <= held_eff;
            target_reg <= target_next;
        end
    end

endmodule

// ===== rtl/core/tcm_mix.sv =====
// Tricopter motor mix and tail servo computation with clamping and saturation.
// Purely combinational; depends on tcm_pkg for the config struct and constants.
module tcm_mix (
    input  tcm_pkg::tcm_cfg_t   cfg,
    input  logic signed [13:0]  thr_eff,
    input  logic signed [11:0]  pitch_correction,
    input  logic signed [11:0]  roll_correction,
    input  logic signed [11:0]  yaw_correction,
    input  logic [11:0]         yaw_stick,
    output logic [11:0]         motor_left,
    output logic [11:0]         motor_right,
    output logic [11:0]         motor_rear,
    output logic [11:0]         tail_servo
);
    import tcm_pkg::*;

    logic signed [12:0] pitch_x2;
    logic signed [13:0] pitch_x4;
    logic [12:0]        mag2;
    logic [13:0]        mag4;
    logic [28:0]        prod2;
    logic [29:0]        prod4;
    logic [10:0]        q2;
    logic [11:0]        q4;
    logic signed [15:0] p23;
    logic signed [15:0] p43;
    logic signed [15:0] thr;
    logic signed [15:0] roll;
    logic signed [15:0] m0_raw;
    logic signed [15:0] m1_raw;
    logic signed [15:0] m2_raw;
    logic signed [15:0] servo_raw;
    logic               low_thr;

    // Clamp to [lo, hi] (hi wins when lo > hi), then saturate to 0..4095.
    function automatic logic [11:0] clamp_sat(
        input logic signed [15:0] x,
        input logic [11:0]        lo,
        input logic [11:0]        hi
    );
        logic signed [15:0] v;
        v = x;
        if (v < $signed({4'b0000, lo}))
        begin
            v = $signed({4'b0000, lo});
        end
        if (v > $signed({4'b0000, hi}))
        begin
            v = $signed({4'b0000, hi});
        end
        if (v < 16'sd0)
        begin
            clamp_sat = '0;
        end
        else if (v > $signed({4'b0000, OUT_MAX}))
        begin
            clamp_sat = OUT_MAX;
        end
        else
        begin
            clamp_sat = v[11:0];
        end
    endfunction

    // Pitch terms 2p/3 and 4p/3, truncated toward zero: divide the magnitude.
    assign pitch_x2 = {pitch_correction, 1'b0};
    assign pitch_x4 = {pitch_correction, 2'b00};
    assign mag2     = pitch_x2[12] ? 13'(-pitch_x2) : pitch_x2[12:0];
    assign mag4     = pitch_x4[13] ? 14'(-pitch_x4) : pitch_x4[13:0];
    assign prod2    = mag2 * DIV3_RECIP;
    assign prod4    = mag4 * DIV3_RECIP;
    assign q2       = prod2[DIV3_SHIFT +: 11];
    assign q4       = prod4[DIV3_SHIFT +: 12];
    assign p23      = pitch_correction[11] ? -$signed({5'b0, q2}) : $signed({5'b0, q2});
    assign p43      = pitch_correction[11] ? -$signed({4'b0, q4}) : $signed({4'b0, q4});

    // Motor mix.
    assign thr     = 16'(thr_eff);
    assign roll    = 16'(roll_correction);
    assign low_thr = (thr <= $signed({4'b0000, cfg.min_throttle}));
    assign m0_raw  = thr + roll - p23;
    assign m1_raw  = thr - roll - p23;
    assign m2_raw  = thr + p43;

    always_comb
    begin
        if (low_thr)
        begin
            motor_left  = clamp_sat(thr, '0, OUT_MAX);
            motor_right = clamp_sat(thr, '0, OUT_MAX);
            motor_rear  = clamp_sat(thr, '0, OUT_MAX);
        end
        else
        begin
            motor_left  = clamp_sat(m0_raw, cfg.min_throttle, cfg.pulse_max);
            motor_right = clamp_sat(m1_raw, cfg.min_throttle, cfg.pulse_max);
            motor_rear  = clamp_sat(m2_raw, cfg.min_throttle, cfg.pulse_max);
        end
    end

    // Tail servo: yaw stick mirrored about the center plus the yaw correction.
    assign servo_raw = $signed({3'b000, cfg.pulse_center, 1'b0})
                     - $signed({4'b0000, yaw_stick})
                     + 16'(yaw_correction);
    assign tail_servo = clamp_sat(servo_raw, cfg.pulse_min, cfg.pulse_max);

endmodule

// ===== rtl/core/tricopter_mixer_alt_hold_unit.sv =====
// Tricopter motor mixer with altitude hold. Each input beat is one control tick;
// it lands in an input register, passes the hold latch and mixer logic, and its
// result beat sits in an output register. Throughput is one beat per clock while
// the sink takes each result; a result beat is valid once its tick has moved from
// the input register into the output register. The hold latch, held throttle and
// target altitude update as the tick moves into the output register, so the next
// tick sees them at once. While a result waits, the input register still takes one
// more beat; after that the input stalls until the sink takes the waiting result.
// Configuration registers (12 bits each) sit at byte addresses 0x00..0x14 and
// must be written only while no tick is in flight. Depends on tcm_pkg, tcm_if,
// tcm_cfg, tcm_hold and tcm_mix.
module tricopter_mixer_alt_hold_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    tcm_in_if.sink                        item_in,
    tcm_out_if.source                     result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcm_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tcm_pkg::*;

    tcm_cfg_t           cfg;
    logic               in_valid_reg;
    logic               in_valid_next;
    tcm_in_t            in_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    tcm_out_t           out_reg;
    tcm_out_t           out_next;
    logic               accept;
    logic               advance;
    tcm_hold_t          hold;
    logic signed [23:0] target_next;

    // Configuration registers.
    tcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the output register frees when empty or taken this cycle.
    assign advance       = !out_valid_reg || result_out.ready;
    assign item_in.ready = !in_valid_reg || advance;
    assign accept        = item_in.valid && item_in.ready;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.throttle_in      <= item_in.throttle_in;
            in_reg.baro_switch      <= item_in.baro_switch;
            in_reg.yaw_stick        <= item_in.yaw_stick;
            in_reg.pitch_correction <= item_in.pitch_correction;
            in_reg.roll_correction  <= item_in.roll_correction;
            in_reg.yaw_correction   <= item_in.yaw_correction;
            in_reg.baro_correction  <= item_in.baro_correction;
            in_reg.est_altitude     <= item_in.est_altitude;
        end
    end

    // Hold latch; its state commits when the tick moves to the output register.
    tcm_hold u_hold (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (in_valid_reg && advance),
        .cfg             (cfg),
        .throttle_in     (in_reg.throttle_in),
        .baro_switch     (in_reg.baro_switch),
        .baro_correction (in_reg.baro_correction),
        .est_altitude    (in_reg.est_altitude),
        .hold            (hold),
        .target_next     (target_next)
    );

    // Motor and servo mix.
    tcm_mix u_mix (
        .cfg              (cfg),
        .thr_eff          (hold.thr_eff),
        .pitch_correction (in_reg.pitch_correction),
        .roll_correction  (in_reg.roll_correction),
        .yaw_correction   (in_reg.yaw_correction),
        .yaw_stick        (in_reg.yaw_stick),
        .motor_left       (out_next.motor_left),
        .motor_right      (out_next.motor_right),
        .motor_rear       (out_next.motor_rear),
        .tail_servo       (out_next.tail_servo)
    );

    assign out_next.hold_active     = hold.active;
    assign out_next.hold_engaged    = hold.engaged;
    assign out_next.altitude_target = target_next;

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.motor_left      = out_reg.motor_left;
    assign result_out.motor_right     = out_reg.motor_right;
    assign result_out.motor_rear      = out_reg.motor_rear;
    assign result_out.tail_servo      = out_reg.tail_servo;
    assign result_out.hold_active     = out_reg.hold_active;
    assign result_out.hold_engaged    = out_reg.hold_engaged;
    assign result_out.altitude_target = out_reg.altitude_target;

endmodule

// ===== rtl/core/tcm_checker.sv =====
// Port-level checker for the tricopter mixer, attached to the top level by bind.
// Depends only on the top level's port names.
module tcm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [11:0]        motor_left,
    input logic               hold_active,
    input logic               hold_engaged,
    input logic signed [23:0] altitude_target
);

    // A waiting result beat stays valid.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A waiting result beat keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(motor_left) && $stable(altitude_target))
        else $error("result payload changed while stalled");

    // Hold cannot release on the tick that engages it.
    a_engage_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_engaged |-> hold_active)
        else $error("engage tick reports hold inactive");

    // Two back-to-back ticks never both engage: the latch is already set.
    a_no_double_engage: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && hold_engaged ##1 out_valid && out_ready
        |-> !hold_engaged)
        else $error("hold engaged on consecutive ticks");

endmodule

bind tricopter_mixer_alt_hold_unit tcm_checker u_tcm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .motor_left      (result_out.motor_left),
    .hold_active     (result_out.hold_active),
    .hold_engaged    (result_out.hold_engaged),
    .altitude_target (result_out.altitude_target)
);
